/* rtl/core/assert_macros.svh */
// assertion macros shared by the rgb to hls core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent true in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent true implies consequent true in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next cycle check failed");

`endif

/* rtl/core/rgb2hls_pkg.sv */
// types, constants and the divider step function of the rgb to hls core
package rgb2hls_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned REM_W    = 17;
  localparam int unsigned QUO_W    = 9;
  localparam int unsigned DEN_W    = 9;
  localparam int unsigned LANES    = 3;
  localparam int unsigned DIV_STAGES = 3;
  localparam int unsigned DIV_STEPS  = QUO_W / DIV_STAGES;

  // lane order inside the divider
  localparam int unsigned LANE_SAT = 0;
  localparam int unsigned LANE_A   = 1;
  localparam int unsigned LANE_B   = 2;

  localparam logic [8:0]  LIGHT_HALF  = 9'd128;
  localparam logic [9:0]  SUM_FULL    = 10'd512;
  localparam logic [11:0] HUE_BASE_G  = 12'd512;
  localparam logic [11:0] HUE_BASE_B  = 12'd1024;
  localparam logic [11:0] RECIP6      = 12'd2731;
  localparam int unsigned RECIP6_SHIFT = 14;
  localparam logic [7:0]  SAT_MAX     = 8'd255;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0]  lane;
    logic [PIX_W-1:0]   light;
    logic               grey;
    max_sel_t           sel;
  } work_t;

  // restoring division, DIV_STEPS quotient bits starting at bit top
  function automatic lane_t div_iter(lane_t l, int unsigned top);
    lane_t            r;
    logic [REM_W-1:0] trial;
    int unsigned      sh;
    r = l;
    for (int unsigned k = 0; k < DIV_STEPS; k++) begin
      sh    = top - k;
      trial = REM_W'(r.den) << sh;
      if (r.rem >= trial) begin
        r.rem     = r.rem - trial;
        r.quo[sh] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/rgb2hls_front.sv */
// first stage: max, min, lightness and divider operand setup
module rgb2hls_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output logic                      out_valid,
  output rgb2hls_pkg::work_t        out_data
);
  import rgb2hls_pkg::*;

  logic [PIX_W-1:0] mx, mn, span, dist_a, dist_b;
  logic [8:0]       sum;
  logic [DEN_W-1:0] sat_den;
  max_sel_t         sel;
  work_t            data_next;

  always_comb begin
    if (red >= green && red >= blue) begin
      mx  = red;
      sel = MAX_RED;
    end else if (green >= blue) begin
      mx  = green;
      sel = MAX_GREEN;
    end else begin
      mx  = blue;
      sel = MAX_BLUE;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    sum  = 9'(mx) + 9'(mn);
    span = mx - mn;
    // lightness below half divides by the sum, otherwise by its complement
    if (sum[8:1] < LIGHT_HALF[7:0]) begin
      sat_den = sum;
    end else begin
      sat_den = DEN_W'(SUM_FULL - 10'(sum));
    end
    // the two channel distances that the hue of this maximum needs
    case (sel)
      MAX_RED: begin
        dist_a = mx - blue;
        dist_b = mx - green;
      end
      MAX_GREEN: begin
        dist_a = mx - red;
        dist_b = mx - blue;
      end
      MAX_BLUE: begin
        dist_a = mx - green;
        dist_b = mx - red;
      end
      default: begin
        dist_a = '0;
        dist_b = '0;
      end
    endcase
    data_next.lane[LANE_SAT] = '{rem: {1'b0, span, 8'b0}, quo: '0, den: sat_den};
    data_next.lane[LANE_A]   = '{rem: {1'b0, dist_a, 8'b0}, quo: '0, den: {1'b0, span}};
    data_next.lane[LANE_B]   = '{rem: {1'b0, dist_b, 8'b0}, quo: '0, den: {1'b0, span}};
    data_next.light = sum[8:1];
    data_next.grey  = (mx == mn);
    data_next.sel   = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

/* rtl/core/rgb2hls_div.sv */
// pipelined restoring dividers for saturation and the two hue distances
module rgb2hls_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  rgb2hls_pkg::work_t        in_data,
  output logic                      out_valid,
  output rgb2hls_pkg::work_t        out_data
);
  import rgb2hls_pkg::*;

  work_t      stg       [DIV_STAGES+1];
  logic       stg_valid [DIV_STAGES+1];

  assign stg[0]       = in_data;
  assign stg_valid[0] = in_valid;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    work_t stg_next;

    always_comb begin
      stg_next = stg[s];
      for (int l = 0; l < LANES; l++) begin
        stg_next.lane[l] = div_iter(stg[s].lane[l], QUO_W - 1 - s * DIV_STEPS);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s+1] <= 1'b0;
      end else begin
        stg_valid[s+1] <= stg_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      stg[s+1] <= stg_next;
    end
  end

  assign out_valid = stg_valid[DIV_STAGES];
  assign out_data  = stg[DIV_STAGES];

endmodule

/* rtl/core/rgb2hls_back.sv */
// hue combine, divide by six by reciprocal, wrap and output registers
module rgb2hls_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  rgb2hls_pkg::work_t        in_data,
  output logic                      done,
  output logic [7:0]                hue,
  output logic [7:0]                lightness,
  output logic [7:0]                saturation
);
  import rgb2hls_pkg::*;

  // combine stage
  logic [11:0]      hv;
  logic [QUO_W-1:0] qa, qb, qs;
  logic             a_valid, a_neg, a_grey;
  logic [10:0]      a_mag, a_mag_next;
  logic [7:0]       a_light, a_sat, a_sat_next;
  // multiply stage
  logic             b_valid, b_neg, b_grey;
  logic [22:0]      b_prod;
  logic [7:0]       b_light, b_sat;
  logic [7:0]       q6;

  always_comb begin
    qs = in_data.lane[LANE_SAT].quo;
    qa = in_data.lane[LANE_A].quo;
    qb = in_data.lane[LANE_B].quo;
    case (in_data.sel)
      MAX_RED:   hv = 12'(qa) - 12'(qb);
      MAX_GREEN: hv = HUE_BASE_G + 12'(qa) - 12'(qb);
      MAX_BLUE:  hv = HUE_BASE_B + 12'(qa) - 12'(qb);
      default:   hv = '0;
    endcase
    // truncation toward zero: divide the magnitude, restore the sign later
    a_mag_next = hv[11] ? 11'(-hv) : hv[10:0];
    a_sat_next = qs[8] ? SAT_MAX : qs[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      done    <= b_valid;
    end
  end

  assign q6 = 8'(b_prod >> RECIP6_SHIFT);

  always_ff @(posedge clk) begin
    a_mag      <= a_mag_next;
    a_neg      <= hv[11];
    a_grey     <= in_data.grey;
    a_light    <= in_data.light;
    a_sat      <= a_sat_next;
    b_prod     <= 23'(a_mag) * 23'(RECIP6);
    b_neg      <= a_neg;
    b_grey     <= a_grey;
    b_light    <= a_light;
    b_sat      <= a_sat;
    lightness  <= b_light;
    saturation <= b_grey ? '0 : b_sat;
    // a negative hue wraps by adding a full turn
    hue        <= b_grey ? '0 : (b_neg ? 8'(-q6) : q6);
  end

endmodule

/* rtl/core/rgb_to_hls_converter_core.sv */
// top level of the pipelined rgb to hls converter
//
//   channel   handshake        payload
//   pixel in  start / busy     red, green, blue
//   result    done (strobe)    hue, lightness, saturation
//
// a pixel can enter every cycle that busy is low; its result strobes out
// after one setup stage, three divider stages of three quotient
// bits each, then combine, reciprocal multiply and output stages.
// busy is high only during reset, which clears the valid bits.
// no stall exists: the result shows for one cycle and must be taken.
module rgb_to_hls_converter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       done,
  output logic [7:0] hue,
  output logic [7:0] lightness,
  output logic [7:0] saturation
);
  import rgb2hls_pkg::*;

  `include "assert_macros.svh"

  logic  front_valid, div_valid, accept;
  work_t front_data, div_data;

  assign busy   = rst;
  assign accept = start && !busy;

  rgb2hls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  rgb2hls_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  rgb2hls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_data    (div_data),
    .done       (done),
    .hue        (hue),
    .lightness  (lightness),
    .saturation (saturation)
  );

  `ASSERT_NEXT(a_front_follows_accept, clk, rst, accept, front_valid)
  `ASSERT_IMPLIES(a_div_latency, clk, rst, div_valid, $past(front_valid, 3))
  `ASSERT_IMPLIES(a_back_latency, clk, rst, done, $past(div_valid, 3))
  `ASSERT_IMPLIES(a_total_latency, clk, rst, done, $past(accept, 7))

endmodule
